/* rtl/rgbg_pkg.sv */
// rgbg_pkg: shared types, mode codes, weights and the gamma 2.2 linear-light table
// for the rgb to gray converter. No dependencies.
package rgbg_pkg;

  localparam int PIX_W     = 8;
  localparam int LIN_W     = 16;
  localparam int LUMA_W    = 16;
  localparam int MODE_W    = 3;
  localparam int LVL_DEPTH = 1 << PIX_W;
  // each search stage resolves two bits of the output level
  localparam int SRCH_STAGES = PIX_W / 2;

  // conversion modes; codes 5 to 7 give a gray level of zero
  typedef enum logic [MODE_W-1:0] {
    MODE_GREEN = 3'd0,
    MODE_AVG   = 3'd1,
    MODE_MID   = 3'd2,
    MODE_NTSC  = 3'd3,
    MODE_HDTV  = 3'd4
  } gray_mode_t;

  // ntsc luma weights, unsigned 0.16
  localparam logic [15:0] NTSC_WR = 16'd19589;
  localparam logic [15:0] NTSC_WG = 16'd38444;
  localparam logic [15:0] NTSC_WB = 16'd7502;

  // hdtv luma weights in linear light, unsigned 0.16, sum is 65536
  localparam logic [15:0] HDTV_WR = 16'd14550;
  localparam logic [15:0] HDTV_WG = 16'd46311;
  localparam logic [15:0] HDTV_WB = 16'd4675;

  // divide by three for sums up to 765: (x * 683) >> 11
  localparam logic [9:0] AVG_RECIP = 10'd683;
  localparam int         AVG_SHIFT = 11;

  // control that travels with each beat down the pipe
  typedef struct packed {
    logic             vld;
    logic             hdtv;
    logic [PIX_W-1:0] gray;
  } rgbg_beat_t;

  // builds round((v/255)^2.2 * 65535) exactly: largest t with
  // (2t-1)^5 * 255^11 <= 32 * v^11 * 65535^5
  function automatic logic [LIN_W*LVL_DEPTH-1:0] build_lin_tab();
    logic [LIN_W*LVL_DEPTH-1:0] tab;
    logic [191:0]               rhs;
    logic [191:0]               lhs;
    logic [16:0]                lo;
    logic [16:0]                hi;
    logic [16:0]                mid;
    tab = '0;
    for (int v = 0; v < LVL_DEPTH; v++) begin
      rhs = 192'd32;
      for (int k = 0; k < 11; k++) rhs = rhs * 192'(v);
      for (int k = 0; k < 5; k++) rhs = rhs * 192'd65535;
      lo = 17'd0;
      hi = 17'd65535;
      for (int it = 0; it < 18; it++) begin
        if (lo < hi) begin
          mid = (lo + hi + 17'd1) >> 1;
          lhs = 192'd1;
          for (int k = 0; k < 5; k++) lhs = lhs * (192'(mid) * 192'd2 - 192'd1);
          for (int k = 0; k < 11; k++) lhs = lhs * 192'd255;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 17'd1;
        end
      end
      tab[v*LIN_W +: LIN_W] = lo[LIN_W-1:0];
    end
    return tab;
  endfunction

  localparam logic [LIN_W*LVL_DEPTH-1:0] LIN_TAB = build_lin_tab();

  // constant table read
  function automatic logic [LIN_W-1:0] lin_lookup(logic [PIX_W-1:0] idx);
    return LIN_TAB[{idx, 4'd0} +: LIN_W];
  endfunction

endpackage

/* rtl/rgb_to_gray_multi_mode_core.sv */
// rgb_to_gray_multi_mode_core: top level of the rgb to gray converter.
// Depends on rgbg_pkg, rgbg_front and rgbg_search.
//
// Usage:
//   A pixel beat (in_red, in_green, in_blue) is taken at a rising edge with
//   start high and busy low. One gray beat per pixel comes back on out_gray,
//   marked by out_strobe for exactly one cycle, in pixel order.
//   Throughput is one pixel per clock; busy is low except during reset and
//   the cycle after it.
//   The pipe is three front stages (table lookup, weight multiply, sum),
//   four search stages that resolve two bits each of the inverse gamma
//   level, and the output register; every stage runs each cycle.
//   cfg_we writes cfg_wdata into the mode register (0 green, 1 average,
//   2 midrange, 3 ntsc luma, 4 hdtv gamma luma, others give zero). The mode
//   is sampled with each pixel; write it only while no pixel is in flight.
//   Synchronous reset (rst_n low) sets mode to green, empties the pipe and
//   drops pixels in flight.
//   The receiver cannot stall: each beat is shown for one cycle only.
module rgb_to_gray_multi_mode_core import rgbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [PIX_W-1:0]  in_red,
  input  logic [PIX_W-1:0]  in_green,
  input  logic [PIX_W-1:0]  in_blue,
  output logic              out_strobe,
  output logic [PIX_W-1:0]  out_gray,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata
);

  logic              busy_r;
  logic [MODE_W-1:0] mode_r;
  logic              out_strobe_r;
  logic [PIX_W-1:0]  out_gray_r;
  logic [PIX_W-1:0]  out_gray_nxt;
  logic              in_vld;
  rgbg_beat_t        c_beat;
  logic [LUMA_W-1:0] c_luma;
  rgbg_beat_t        s_beat;
  logic [PIX_W-1:0]  s_level;

  // busy high in reset, cleared at the first clock edge with reset released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GREEN;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign in_vld = start && !busy_r;

  rgbg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_mode  (mode_r),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .c_beat   (c_beat),
    .c_luma   (c_luma)
  );

  rgbg_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_beat  (c_beat),
    .s_luma  (c_luma),
    .o_beat  (s_beat),
    .o_level (s_level)
  );

  // final pick between gamma search level and the other modes
  assign out_gray_nxt = s_beat.hdtv ? s_level : s_beat.gray;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s_beat.vld;
    end
    out_gray_r <= out_gray_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_gray   = out_gray_r;

endmodule

/* rtl/rgbg_front.sv */
// rgbg_front: first three pipeline stages of the converter: table lookup and
// channel stats, weight multiplies, then sums. Depends on rgbg_pkg.
module rgbg_front import rgbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [PIX_W-1:0]  in_red,
  input  logic [PIX_W-1:0]  in_green,
  input  logic [PIX_W-1:0]  in_blue,
  output rgbg_beat_t        c_beat,
  output logic [LUMA_W-1:0] c_luma
);

  // stage a registers
  logic              a_vld_r;
  logic [MODE_W-1:0] a_mode_r;
  logic [PIX_W-1:0]  a_red_r, a_green_r, a_blue_r;
  logic [LIN_W-1:0]  a_lin_r_r, a_lin_g_r, a_lin_b_r;
  logic [9:0]        a_sum3_r;
  logic [PIX_W-1:0]  a_mid_r;

  // stage b registers
  logic              b_vld_r;
  logic [MODE_W-1:0] b_mode_r;
  logic [PIX_W-1:0]  b_simple_r;
  logic [31:0]       b_hr_r, b_hg_r, b_hb_r;
  logic [23:0]       b_nr_r, b_ng_r, b_nb_r;

  // stage c registers
  rgbg_beat_t        c_beat_r;
  logic [LUMA_W-1:0] c_luma_r;

  logic [PIX_W-1:0]  mx, mn;
  logic [PIX_W:0]    mid_sum;
  logic [19:0]       avg_prod;
  logic [PIX_W-1:0]  b_simple_nxt;
  logic [32:0]       hdtv_sum;
  logic [24:0]       ntsc_sum;
  rgbg_beat_t        c_beat_nxt;

  // max and min over the three channels
  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    mid_sum = {1'b0, mx} + {1'b0, mn};
  end

  // stage a: capture pixel, linear-light lookups, channel sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    a_mode_r  <= in_mode;
    a_red_r   <= in_red;
    a_green_r <= in_green;
    a_blue_r  <= in_blue;
    a_lin_r_r <= lin_lookup(in_red);
    a_lin_g_r <= lin_lookup(in_green);
    a_lin_b_r <= lin_lookup(in_blue);
    a_sum3_r  <= 10'(in_red) + 10'(in_green) + 10'(in_blue);
    a_mid_r   <= mid_sum[PIX_W:1];
  end

  // simple modes and divide by three
  always_comb begin
    avg_prod = 20'(a_sum3_r) * 20'(AVG_RECIP);
    unique case (a_mode_r)
      MODE_GREEN: b_simple_nxt = a_green_r;
      MODE_AVG:   b_simple_nxt = avg_prod[AVG_SHIFT +: PIX_W];
      MODE_MID:   b_simple_nxt = a_mid_r;
      default:    b_simple_nxt = '0;
    endcase
  end

  // stage b: weight multiplies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_mode_r   <= a_mode_r;
    b_simple_r <= b_simple_nxt;
    b_hr_r     <= 32'(a_lin_r_r) * 32'(HDTV_WR);
    b_hg_r     <= 32'(a_lin_g_r) * 32'(HDTV_WG);
    b_hb_r     <= 32'(a_lin_b_r) * 32'(HDTV_WB);
    b_nr_r     <= 24'(a_red_r) * 24'(NTSC_WR);
    b_ng_r     <= 24'(a_green_r) * 24'(NTSC_WG);
    b_nb_r     <= 24'(a_blue_r) * 24'(NTSC_WB);
  end

  // weighted sums and mode select
  always_comb begin
    hdtv_sum = 33'(b_hr_r) + 33'(b_hg_r) + 33'(b_hb_r);
    ntsc_sum = 25'(b_nr_r) + 25'(b_ng_r) + 25'(b_nb_r);
    c_beat_nxt.vld  = b_vld_r;
    c_beat_nxt.hdtv = (b_mode_r == MODE_HDTV);
    c_beat_nxt.gray = (b_mode_r == MODE_NTSC) ? ntsc_sum[16 +: PIX_W] : b_simple_r;
  end

  // stage c: sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_beat_r <= '0;
    end else begin
      c_beat_r <= c_beat_nxt;
    end
    c_luma_r <= hdtv_sum[16 +: LUMA_W];
  end

  assign c_beat = c_beat_r;
  assign c_luma = c_luma_r;

endmodule

/* rtl/rgbg_search.sv */
// rgbg_search: inverse gamma by binary search over the linear-light table,
// two output bits per pipeline stage. Depends on rgbg_pkg.
module rgbg_search import rgbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rgbg_beat_t        s_beat,
  input  logic [LUMA_W-1:0] s_luma,
  output rgbg_beat_t        o_beat,
  output logic [PIX_W-1:0]  o_level
);

  rgbg_beat_t        beat_r    [SRCH_STAGES];
  logic [LUMA_W-1:0] luma_r    [SRCH_STAGES];
  logic [PIX_W-1:0]  lvl_r     [SRCH_STAGES];
  rgbg_beat_t        beat_nxt  [SRCH_STAGES];
  logic [LUMA_W-1:0] luma_nxt  [SRCH_STAGES];
  logic [PIX_W-1:0]  lvl_nxt   [SRCH_STAGES];

  // per stage: try setting the next two bits, keep each if table entry fits
  always_comb begin
    logic [PIX_W-1:0] lvl_in;
    logic [PIX_W-1:0] cand_hi;
    logic [PIX_W-1:0] lvl_mid;
    logic [PIX_W-1:0] cand_lo;
    for (int s = 0; s < SRCH_STAGES; s++) begin
      if (s == 0) begin
        beat_nxt[s] = s_beat;
        luma_nxt[s] = s_luma;
        lvl_in      = '0;
      end else begin
        beat_nxt[s] = beat_r[s-1];
        luma_nxt[s] = luma_r[s-1];
        lvl_in      = lvl_r[s-1];
      end
      cand_hi    = lvl_in | (PIX_W'(1) << (PIX_W - 1 - 2 * s));
      lvl_mid    = (lin_lookup(cand_hi) <= luma_nxt[s]) ? cand_hi : lvl_in;
      cand_lo    = lvl_mid | (PIX_W'(1) << (PIX_W - 2 - 2 * s));
      lvl_nxt[s] = (lin_lookup(cand_lo) <= luma_nxt[s]) ? cand_lo : lvl_mid;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int s = 0; s < SRCH_STAGES; s++) begin
      if (!rst_n) begin
        beat_r[s] <= '0;
      end else begin
        beat_r[s] <= beat_nxt[s];
      end
      luma_r[s] <= luma_nxt[s];
      lvl_r[s]  <= lvl_nxt[s];
    end
  end

  assign o_beat  = beat_r[SRCH_STAGES-1];
  assign o_level = lvl_r[SRCH_STAGES-1];

endmodule

/* rtl/rgbg_checker.sv */
// rgbg_checker: port-level assertions for rgb_to_gray_multi_mode_core and the
// bind that attaches them. Depends on rgbg_pkg.
module rgbg_checker import rgbg_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic [PIX_W-1:0]  out_gray
);

  // every accepted beat comes out on out_strobe
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_strobe)
    else $error("accepted pixel beat did not come out");

  // no result beat without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 8))
    else $error("result beat without accepted pixel");

  // reset empties the pipe
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result beat right after reset");

  // busy is low whenever rst_n is high and was high at the last sample too
  a_busy_low: assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy high outside reset");

  // a result beat never carries unknown bits
  a_gray_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown(out_gray))
    else $error("result beat with unknown gray level");

endmodule

bind rgb_to_gray_multi_mode_core rgbg_checker u_rgbg_checker (.*);

/* bench/rgb_to_gray_multi_mode_core_tb.sv */
// rgb_to_gray_multi_mode_core_tb: self-checking bench for the rgb to gray converter,
// predicting every gray beat in all mode codes under random sender idling.
// Depends on rgbg_pkg and rgb_to_gray_multi_mode_core.
module rgb_to_gray_multi_mode_core_tb;
  import rgbg_pkg::*;

  localparam int PIPE_LATENCY   = 8;
  localparam int STALL_LIMIT    = 2000;
  localparam int BEATS_PER_MODE = 60;
  localparam int MODE_CODES     = 1 << MODE_W;
  localparam int LIN_MAX        = (1 << LIN_W) - 1;
  localparam int PIX_MAX        = (1 << PIX_W) - 1;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } pixel_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [PIX_W-1:0]  in_red = '0;
  logic [PIX_W-1:0]  in_green = '0;
  logic [PIX_W-1:0]  in_blue = '0;
  logic              out_strobe;
  logic [PIX_W-1:0]  out_gray;
  logic              cfg_we = 1'b0;
  logic [MODE_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [LIN_W-1:0]  gamma_lin [LVL_DEPTH];
  logic [MODE_W-1:0] cur_mode = MODE_GREEN;
  logic [PIX_W-1:0]  gray_expected_q [$];
  logic [PIX_W-1:0]  gray_want;
  int                idle_pct = 0;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;

  rgb_to_gray_multi_mode_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .out_strobe (out_strobe),
    .out_gray   (out_gray),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // gamma 2.2 table: t only grows with v, so each entry continues the
  // search where the previous one stopped
  function automatic void build_gamma_table();
    logic [191:0] bound;
    logic [191:0] pow255;
    logic [191:0] odd;
    logic [191:0] trial;
    logic         grow;
    int           t;
    pow255 = 192'd1;
    repeat (11) pow255 = pow255 * 192'd255;
    t = 0;
    for (int v = 0; v < LVL_DEPTH; v++) begin
      bound = 192'd32;
      repeat (11) bound = bound * 192'(v);
      repeat (5) bound = bound * 192'd65535;
      grow = 1'b1;
      while (grow && t < LIN_MAX) begin
        odd = 192'(2 * t + 1);
        trial = pow255;
        repeat (5) trial = trial * odd;
        if (trial <= bound) t++;
        else grow = 1'b0;
      end
      gamma_lin[v] = t[LIN_W-1:0];
    end
  endfunction

  // expected gray level of one pixel in the given mode
  function automatic logic [PIX_W-1:0] predict_gray(logic [MODE_W-1:0] mode, pixel_t px);
    logic [9:0]       sum3;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    logic [PIX_W:0]   mid;
    logic [31:0]      luma;
    logic [PIX_W-1:0] lvl;
    sum3 = 10'(px.r) + 10'(px.g) + 10'(px.b);
    hi = px.r;
    lo = px.r;
    if (px.g > hi) hi = px.g;
    if (px.b > hi) hi = px.b;
    if (px.g < lo) lo = px.g;
    if (px.b < lo) lo = px.b;
    mid = ({1'b0, hi} + {1'b0, lo}) >> 1;
    lvl = '0;
    case (mode)
      MODE_GREEN: lvl = px.g;
      MODE_AVG:   lvl = PIX_W'(sum3 / 10'd3);
      MODE_MID:   lvl = mid[PIX_W-1:0];
      MODE_NTSC: begin
        luma = (32'd19589 * 32'(px.r) + 32'd38444 * 32'(px.g)
                + 32'd7502 * 32'(px.b)) >> 16;
        lvl = luma[PIX_W-1:0];
      end
      MODE_HDTV: begin
        luma = (32'd14550 * 32'(gamma_lin[px.r]) + 32'd46311 * 32'(gamma_lin[px.g])
                + 32'd4675 * 32'(gamma_lin[px.b])) >> 16;
        // largest level whose linear value does not exceed the luma
        for (int v = 0; v < LVL_DEPTH; v++)
          if (32'(gamma_lin[v]) <= luma) lvl = v[PIX_W-1:0];
      end
      default: lvl = '0;
    endcase
    return lvl;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     kind;
    kind = $urandom_range(9);
    px.r = PIX_W'($urandom_range(PIX_MAX));
    px.g = PIX_W'($urandom_range(PIX_MAX));
    px.b = PIX_W'($urandom_range(PIX_MAX));
    case (kind)
      // channels pinned to the rails
      0: begin
        px.r = $urandom_range(1) ? '1 : '0;
        px.g = $urandom_range(1) ? '1 : '0;
        px.b = $urandom_range(1) ? '1 : '0;
      end
      // neutral gray
      1: begin
        px.g = px.r;
        px.b = px.r;
      end
      // near the ends of the range
      2: begin
        px.r = PIX_W'($urandom_range(1) ? $urandom_range(3) : PIX_MAX - $urandom_range(3));
        px.g = PIX_W'($urandom_range(1) ? $urandom_range(3) : PIX_MAX - $urandom_range(3));
        px.b = PIX_W'($urandom_range(1) ? $urandom_range(3) : PIX_MAX - $urandom_range(3));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // one pixel beat; start is left high unless the sender idles afterwards
  task automatic send_pixel(pixel_t px);
    start <= 1'b1;
    in_red <= px.r;
    in_green <= px.g;
    in_blue <= px.b;
    do @(posedge clk); while (busy !== 1'b0);
    gray_expected_q.push_back(predict_gray(cur_mode, px));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // sender holds off until every gray beat is back
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (gray_expected_q.size() != 0);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] mode);
    hold_until_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = mode;
  endtask

  task automatic test_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // black, white and one further test pixel in every mode code, spare codes too
  task automatic test_directed_modes();
    pixel_t tint [MODE_CODES];
    pixel_t px;
    tint[0] = '{r: 8'd255, g: 8'd0,   b: 8'd128};
    tint[1] = '{r: 8'd255, g: 8'd255, b: 8'd254};
    tint[2] = '{r: 8'd200, g: 8'd10,  b: 8'd90};
    tint[3] = '{r: 8'd255, g: 8'd0,   b: 8'd0};
    tint[4] = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
    tint[5] = '{r: 8'd3,   g: 8'd250, b: 8'd7};
    tint[6] = '{r: 8'd85,  g: 8'd170, b: 8'd1};
    tint[7] = '{r: 8'd1,   g: 8'd1,   b: 8'd1};
    for (int m = 0; m < MODE_CODES; m++) begin
      write_mode(m[MODE_W-1:0]);
      px = '0;
      send_pixel(px);
      px = '1;
      send_pixel(px);
      send_pixel(tint[m]);
    end
  endtask

  // every mode code in shuffled order, with one drain pause inside each run
  task automatic test_random_mix();
    logic [MODE_W-1:0] order [MODE_CODES];
    logic [MODE_W-1:0] swap;
    int                j;
    int                hold_at;
    for (int m = 0; m < MODE_CODES; m++) order[m] = m[MODE_W-1:0];
    for (int i = MODE_CODES - 1; i > 0; i--) begin
      j = $urandom_range(i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (int m = 0; m < MODE_CODES; m++) begin
      write_mode(order[m]);
      hold_at = $urandom_range(BEATS_PER_MODE - 1);
      for (int i = 0; i < BEATS_PER_MODE; i++) begin
        send_pixel(random_pixel());
        if (i == hold_at) hold_until_drained();
      end
    end
  endtask

  // gray beat check and activity count
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (rst_n && out_strobe === 1'b1) begin
      if (gray_expected_q.size() == 0) begin
        report_mismatch($sformatf("gray beat %0d with nothing expected", out_gray));
      end else begin
        gray_want = gray_expected_q.pop_front();
        if (out_gray !== gray_want)
          report_mismatch($sformatf("gray %0d, expected %0d", out_gray, gray_want));
      end
    end
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    build_gamma_table();
    test_reset();
    idle_pct = 32;
    test_directed_modes();
    test_random_mix();
    idle_pct = 86;
    test_random_mix();
    idle_pct = 0;
    test_random_mix();
    hold_until_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (gray_expected_q.size() == 0 && mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rgbg_pkg.sv
rtl/rgbg_front.sv
rtl/rgbg_search.sv
rtl/rgb_to_gray_multi_mode_core.sv
rtl/rgbg_checker.sv
bench/rgb_to_gray_multi_mode_core_tb.sv
